/* design/http_get_packet_byte_corrupter_defines.svh */
// Assertion macros shared by the corrupter RTL.
// Assertions sample on clk_i and are masked while rst_ni is low.
`ifndef HTTP_GET_PACKET_BYTE_CORRUPTER_DEFINES_SVH
`define HTTP_GET_PACKET_BYTE_CORRUPTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// plain property check
`define HGPBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// overlapping implication
`define HGPBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define HGPBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HGPBC_ASSERT(lbl, prop, msg)
`define HGPBC_ASSERT_IMP(lbl, ante, cons, msg)
`define HGPBC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* design/hgpbc_pkg.sv */
// Shared types and constants of the HTTP GET packet byte corrupter.
// No dependencies; used by every module of the block.
package hgpbc_pkg;

  // frame position counter
  localparam int unsigned POS_BITS = 16;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // output queue
  localparam int unsigned RES_MAX   = 4;
  localparam int unsigned QDEPTH    = 8;
  localparam int unsigned QPTR_BITS = 3;
  localparam int unsigned QCNT_BITS = 4;

  // register map
  localparam int unsigned CFG_DATA_BITS = 32;
  typedef enum logic [0:0] {
    REG_CORRUPT_THRESHOLD = 1'b0,
    REG_MIN_IP_TOTAL_LEN  = 1'b1
  } reg_idx_e;

  // protocol constants
  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
  localparam logic [15:0] ETYPE_VLAN  = 16'h8100;
  localparam logic [15:0] ETYPE_QINQ  = 16'h88A8;
  localparam logic [7:0]  IP_PROTO_TCP = 8'd6;
  localparam logic [4:0]  IP_START_UNTAGGED = 5'd14;
  localparam logic [4:0]  IP_START_TAGGED   = 5'd18;
  localparam logic [7:0]  CHAR_G = 8'h47;
  localparam logic [7:0]  CHAR_E = 8'h45;
  localparam logic [7:0]  CHAR_T = 8'h54;

  localparam logic [31:0] CORRUPT_THRESHOLD_RST = 32'h8000_0000;
  localparam logic [15:0] MIN_IP_TOTAL_LEN_RST  = 16'd52;

  typedef struct packed {
    logic [31:0] corrupt_threshold;
    logic [15:0] min_ip_total_length;
  } cfg_t;

  // one output transaction
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       alt;
  } res_t;

  // results produced by one input transaction
  typedef struct packed {
    res_t [RES_MAX-1:0] item;
    logic [2:0]         n;
  } res_bus_t;

endpackage

/* design/http_get_packet_byte_corrupter.sv */
// HTTP GET packet byte corrupter. Takes an Ethernet frame one byte per transaction and
// passes every byte on three bytes late; for TCP frames (untagged or with one VLAN/QinQ
// tag, fixed 20-byte IPv4 header) whose payload opens with "GET", whose IP total length
// exceeds min_ip_total_length and whose random word at payload byte 7 exceeds
// corrupt_threshold, payload byte 4 is replaced by the random word's low byte and flagged
// on tuser. One byte is accepted per clock while the output queue has room. The final
// byte of a frame releases up to four output transactions at once into an eight-entry
// output queue; input is held off while fewer than four entries are free. With a sink
// taking one per clock the queue never holds more than four entries, so the input never
// stalls; a slower sink backs the queue up and then holds off the input until it drains.
// Results are written into the queue's registers and leave it from there.
// Depends on hgpbc_pkg, hgpbc_parser and hgpbc_outq.

module http_get_packet_byte_corrupter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [hgpbc_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  // input byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] frame_byte, [39:8] random_word
  input  logic        s_axis_tlast,   // last_byte
  // output byte stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // out_last
  output logic [0:0]  m_axis_tuser    // [0] was_altered
);
  import hgpbc_pkg::*;

  cfg_t     cfg_q;
  res_bus_t res;
  res_t     head;
  logic     in_acc;
  logic     room;

  assign s_axis_tready = room;
  assign in_acc        = s_axis_tvalid && room;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.corrupt_threshold   <= CORRUPT_THRESHOLD_RST;
      cfg_q.min_ip_total_length <= MIN_IP_TOTAL_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CORRUPT_THRESHOLD: cfg_q.corrupt_threshold   <= cfg_wdata_i;
        REG_MIN_IP_TOTAL_LEN:  cfg_q.min_ip_total_length <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  hgpbc_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_acc_i      (in_acc),
    .frame_byte_i  (s_axis_tdata[7:0]),
    .last_byte_i   (s_axis_tlast),
    .random_word_i (s_axis_tdata[39:8]),
    .res_o         (res)
  );

  hgpbc_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata    = head.data;
  assign m_axis_tlast    = head.last;
  assign m_axis_tuser[0] = head.alt;

endmodule

/* design/hgpbc_parser.sv */
// Frame parser, GET matcher and three-byte delay line of the corrupter.
// Depends on hgpbc_pkg and the assertion macro header.
`include "http_get_packet_byte_corrupter_defines.svh"

module hgpbc_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hgpbc_pkg::cfg_t      cfg_i,
  input  logic                 in_acc_i,
  input  logic [7:0]           frame_byte_i,
  input  logic                 last_byte_i,
  input  logic [31:0]          random_word_i,
  output hgpbc_pkg::res_bus_t  res_o
);
  import hgpbc_pkg::*;

  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [15:0]         type_q, type_d;
  logic [4:0]          ip_q, ip_d;
  logic                tcp_q, tcp_d;
  logic [15:0]         len_q, len_d;
  logic [6:0]          ps_q, ps_d;
  logic [1:0]          mp_q, mp_d;
  logic [7:0]          line_q [3];
  logic [7:0]          line_d [3];
  logic [1:0]          fill_q, fill_d;

  logic [POS_BITS-1:0] ipx, psx;
  logic [3:0]          doff;
  logic                alt;
  logic [7:0]          head;
  logic [7:0]          ext [RES_MAX];
  logic [15:0]         type_lo;

  assign ipx     = POS_BITS'(ip_q);
  assign psx     = POS_BITS'(ps_q);
  assign doff    = frame_byte_i[7:4];
  assign type_lo = type_q | {8'h00, frame_byte_i};

  // header parsing and match tracking
  always_comb begin
    type_d = type_q;
    ip_d   = ip_q;
    tcp_d  = tcp_q;
    len_d  = len_q;
    ps_d   = ps_q;
    mp_d   = mp_q;
    alt    = 1'b0;

    // ethertype, optional single tag
    if (pos_q == POS_BITS'(12)) begin
      type_d = {frame_byte_i, 8'h00};
    end else if (pos_q == POS_BITS'(13)) begin
      type_d = type_lo;
      if (type_lo == ETYPE_IPV4) ip_d = IP_START_UNTAGGED;
    end else if (pos_q == POS_BITS'(16)) begin
      type_d = (type_q == ETYPE_VLAN || type_q == ETYPE_QINQ) ?
               {frame_byte_i, 8'h00} : 16'h0000;
    end else if (pos_q == POS_BITS'(17)) begin
      if (type_q == ETYPE_IPV4 && frame_byte_i == 8'h00) ip_d = IP_START_TAGGED;
    end

    // IPv4 total length, protocol, TCP data offset
    if (ip_q != 5'd0) begin
      if (pos_q == ipx + POS_BITS'(2)) begin
        len_d = {frame_byte_i, 8'h00};
      end else if (pos_q == ipx + POS_BITS'(3)) begin
        len_d = len_q | {8'h00, frame_byte_i};
      end else if (pos_q == ipx + POS_BITS'(9)) begin
        tcp_d = (frame_byte_i == IP_PROTO_TCP);
      end else if (pos_q == ipx + POS_BITS'(32)) begin
        if (tcp_q && doff >= 4'd5)
          ps_d = 7'(ip_q) + 7'd20 + {1'b0, doff, 2'b00};
      end
    end

    // payload "GET" and corruption decision
    if (ps_q != 7'd0) begin
      if (pos_q == psx) begin
        mp_d = (frame_byte_i == CHAR_G) ? 2'd1 : 2'd0;
      end else if (pos_q == psx + POS_BITS'(1)) begin
        mp_d = (mp_q == 2'd1 && frame_byte_i == CHAR_E) ? 2'd2 : 2'd0;
      end else if (pos_q == psx + POS_BITS'(2)) begin
        mp_d = (mp_q == 2'd2 && frame_byte_i == CHAR_T) ? 2'd3 : 2'd0;
      end else if (pos_q == psx + POS_BITS'(7)) begin
        alt = (mp_q == 2'd3) && (len_q > cfg_i.min_ip_total_length) &&
              (random_word_i > cfg_i.corrupt_threshold) && (fill_q == 2'd3);
      end
    end
  end

  assign head   = alt ? random_word_i[7:0] : line_q[0];
  assign ext[0] = head;
  assign ext[1] = line_q[1];
  assign ext[2] = line_q[2];
  assign ext[3] = frame_byte_i;

  // results and delay line update
  always_comb begin
    res_o       = '0;
    line_d      = line_q;
    fill_d      = fill_q;
    pos_d       = (pos_q != POS_MAX) ? pos_q + POS_BITS'(1) : pos_q;
    if (last_byte_i) begin
      // flush held bytes, then the final byte
      for (int i = 0; i < RES_MAX; i++) begin
        res_o.item[i].data = (i == int'(fill_q)) ? frame_byte_i : ext[i];
        res_o.item[i].last = (i == int'(fill_q));
        res_o.item[i].alt  = (i == 0) && alt;
      end
      res_o.n = 3'(fill_q) + 3'd1;
    end else if (fill_q == 2'd3) begin
      res_o.item[0] = '{data: head, last: 1'b0, alt: alt};
      res_o.n       = 3'd1;
      line_d[0]     = line_q[1];
      line_d[1]     = line_q[2];
      line_d[2]     = frame_byte_i;
    end else begin
      unique case (fill_q)
        2'd0:    line_d[0] = frame_byte_i;
        2'd1:    line_d[1] = frame_byte_i;
        default: line_d[2] = frame_byte_i;
      endcase
      fill_d = fill_q + 2'd1;
    end
    if (!in_acc_i) res_o.n = 3'd0;
  end

  // frame state; a final byte returns everything to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      type_q <= '0;
      ip_q   <= '0;
      tcp_q  <= 1'b0;
      len_q  <= '0;
      ps_q   <= '0;
      mp_q   <= '0;
      fill_q <= '0;
      for (int i = 0; i < 3; i++) line_q[i] <= '0;
    end else if (in_acc_i) begin
      if (last_byte_i) begin
        pos_q  <= '0;
        type_q <= '0;
        ip_q   <= '0;
        tcp_q  <= 1'b0;
        len_q  <= '0;
        ps_q   <= '0;
        mp_q   <= '0;
        fill_q <= '0;
        for (int i = 0; i < 3; i++) line_q[i] <= '0;
      end else begin
        pos_q  <= pos_d;
        type_q <= type_d;
        ip_q   <= ip_d;
        tcp_q  <= tcp_d;
        len_q  <= len_d;
        ps_q   <= ps_d;
        mp_q   <= mp_d;
        fill_q <= fill_d;
        line_q <= line_d;
      end
    end
  end

  `HGPBC_ASSERT_NXT(a_frame_clear, in_acc_i && last_byte_i,
                    pos_q == '0 && fill_q == 2'd0, "frame state not cleared after final byte")
  `HGPBC_ASSERT_IMP(a_alt_needs_full, alt, fill_q == 2'd3 && mp_q == 2'd3,
                    "byte altered without full delay line and match")

endmodule

/* design/hgpbc_outq.sv */
// Output queue: takes up to four results a cycle, hands out one per transaction.
// Depends on hgpbc_pkg and the assertion macro header.
`include "http_get_packet_byte_corrupter_defines.svh"

module hgpbc_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hgpbc_pkg::res_bus_t wr_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                ready_i,
  output hgpbc_pkg::res_t     head_o
);
  import hgpbc_pkg::*;

  res_t                 mem_q [QDEPTH];
  logic [QPTR_BITS-1:0] wptr_q, rptr_q;
  logic [QCNT_BITS-1:0] cnt_q;
  logic                 rd;

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];
  assign rd      = valid_o && ready_i;
  // room for a worst-case burst from one final byte
  assign room_o  = (cnt_q <= QCNT_BITS'(QDEPTH - RES_MAX));

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < RES_MAX; i++) begin
      if (3'(i) < wr_i.n) mem_q[wptr_q + QPTR_BITS'(i)] <= wr_i.item[i];
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + QPTR_BITS'(wr_i.n);
      rptr_q <= rptr_q + QPTR_BITS'(rd);
      cnt_q  <= cnt_q + QCNT_BITS'(wr_i.n) - QCNT_BITS'(rd);
    end
  end

  `HGPBC_ASSERT(a_cnt_bound, cnt_q <= QCNT_BITS'(QDEPTH), "queue fill level exceeds depth")
  `HGPBC_ASSERT_IMP(a_no_overrun, wr_i.n != 3'd0, room_o, "results written without room")

endmodule
